[sv/dfc_pkg.sv]
// Shared types, codes and CRC helper for the message deframer with CRC-32 check.
package dfc_pkg;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [3:0] PH_OFFSET    = 4'd0;
    localparam logic [3:0] PH_TIMESTAMP = 4'd1;
    localparam logic [3:0] PH_PARTITION = 4'd2;
    localparam logic [3:0] PH_CHECKSUM  = 4'd3;
    localparam logic [3:0] PH_PRIORITY  = 4'd4;
    localparam logic [3:0] PH_CODEC     = 4'd5;
    localparam logic [3:0] PH_KEYLEN    = 4'd6;
    localparam logic [3:0] PH_KEY       = 4'd7;
    localparam logic [3:0] PH_VALLEN    = 4'd8;
    localparam logic [3:0] PH_VALUE     = 4'd9;
    localparam logic [3:0] PH_DONE      = 4'd10;

    localparam logic [1:0] KIND_KEY     = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [63:0] offset;
        logic [63:0] timestamp;
        logic [31:0] partition;
        logic [31:0] checksum;
        logic [7:0]  priority_b;
        logic [7:0]  codec;
        logic [31:0] key_len;
        logic [31:0] value_len;
        logic        valid;
        logic        crc_match;
    } summary_t;

    typedef struct packed {
        logic       has_data;
        logic       is_value;
        logic [7:0] data_byte;
        logic       has_sum;
        summary_t   sum;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } qlink_t;

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [3:0] head_width(input logic [3:0] ph);
        logic [3:0] w;
        case (ph)
            PH_OFFSET:    w = 4'd8;
            PH_TIMESTAMP: w = 4'd8;
            PH_PARTITION: w = 4'd4;
            PH_CHECKSUM:  w = 4'd4;
            PH_PRIORITY:  w = 4'd1;
            PH_CODEC:     w = 4'd1;
            PH_KEYLEN:    w = 4'd4;
            PH_VALLEN:    w = 4'd4;
            default:      w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

[sv/dfc_if.sv]
// Valid/ready channel interfaces for the deframer input bytes and result beats.
interface dfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_buffer;

    modport source (output valid, output in_byte, output end_of_buffer, input ready);
    modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

interface dfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] msg_offset;
    logic [63:0] msg_timestamp;
    logic [31:0] msg_partition;
    logic [31:0] stored_crc;
    logic [7:0]  msg_priority;
    logic [7:0]  msg_codec;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        msg_valid;
    logic        crc_match;

    modport source (output valid, output kind, output payload_byte, output msg_offset,
                    output msg_timestamp, output msg_partition, output stored_crc,
                    output msg_priority, output msg_codec, output key_length,
                    output value_length, output msg_valid, output crc_match,
                    input ready);
    modport sink (input valid, input kind, input payload_byte, input msg_offset,
                  input msg_timestamp, input msg_partition, input stored_crc,
                  input msg_priority, input msg_codec, input key_length,
                  input value_length, input msg_valid, input crc_match,
                  output ready);
endinterface

[sv/message_deframer_crc32_check_top.sv]
// Top level of the message deframer with CRC-32 check.
//
//   channel  dir  beat                          payload
//   rx       in   one message byte              in_byte, end_of_buffer
//   tx       out  key byte, value byte, summary kind, payload_byte, header fields, flags
//
// One byte is taken per cycle while the queue is not full; the CRC byte update and
// field shift finish in that cycle. Each byte yields zero, one or two tx beats;
// a marked last byte that carries a key or value byte needs two tx beats, so the
// four-entry queue absorbs the burst. A result beat passes through the queue and then
// the back holding register before it is offered on tx.
// rx stalls only when the queue is full; tx stalls hold the current beat.
// Reset returns the parser to the offset field with the CRC at all ones.
module message_deframer_crc32_check_top
    import dfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dfc_in_if.sink    rx,
    dfc_out_if.source tx
);

    qlink_t push;
    qlink_t pop;
    logic   queue_full;
    logic   pop_ready;

    dfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .queue_full (queue_full),
        .push       (push)
    );

    dfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (queue_full),
        .pop       (pop),
        .pop_ready (pop_ready)
    );

    dfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_ready (pop_ready),
        .tx        (tx)
    );

endmodule

[sv/dfc_front.sv]
// Front parser: accepts message bytes, tracks fields and CRC, queues result entries.
module dfc_front
    import dfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dfc_in_if.sink     rx,
    input  logic       queue_full,
    output qlink_t     push
);

    logic [3:0]  phase_reg,     phase_next;
    logic [31:0] count_reg,     count_next;
    logic [63:0] shift_reg,     shift_next;
    logic [31:0] crc_reg,       crc_next;
    logic [63:0] offset_reg,    offset_next;
    logic [63:0] timestamp_reg, timestamp_next;
    logic [31:0] partition_reg, partition_next;
    logic [31:0] checksum_reg,  checksum_next;
    logic [7:0]  priority_reg,  priority_next;
    logic [7:0]  codec_reg,     codec_next;
    logic [31:0] key_len_reg,   key_len_next;
    logic [31:0] value_len_reg, value_len_next;

    logic        accept;
    logic        is_head;
    logic        is_body;
    logic        crc_phase;
    logic [31:0] count_inc;
    logic [63:0] shift_in;
    logic [31:0] body_len;
    summary_t    sum;

    assign rx.ready = !queue_full;
    assign accept   = rx.valid && rx.ready;

    assign is_head   = (phase_reg <= PH_VALLEN) && (phase_reg != PH_KEY);
    assign is_body   = (phase_reg == PH_KEY) || (phase_reg == PH_VALUE);
    assign crc_phase = (phase_reg == PH_OFFSET) || (phase_reg == PH_TIMESTAMP)
                    || (phase_reg == PH_PRIORITY) || (phase_reg == PH_CODEC);
    assign count_inc = count_reg + 32'd1;
    assign shift_in  = shift_reg | ({56'd0, rx.in_byte} << {count_reg[2:0], 3'b000});
    assign body_len  = (phase_reg == PH_KEY) ? key_len_reg : value_len_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        shift_next     = shift_reg;
        crc_next       = crc_reg;
        offset_next    = offset_reg;
        timestamp_next = timestamp_reg;
        partition_next = partition_reg;
        checksum_next  = checksum_reg;
        priority_next  = priority_reg;
        codec_next     = codec_reg;
        key_len_next   = key_len_reg;
        value_len_next = value_len_reg;

        if (accept && is_head)
        begin
            if (crc_phase)
            begin
                crc_next = crc32_byte(crc_reg, rx.in_byte);
            end
            if (count_inc == {28'd0, head_width(phase_reg)})
            begin
                phase_next = phase_reg + 4'd1;
                count_next = 32'd0;
                shift_next = 64'd0;
                case (phase_reg)
                    PH_OFFSET:    offset_next    = shift_in;
                    PH_TIMESTAMP: timestamp_next = shift_in;
                    PH_PARTITION: partition_next = shift_in[31:0];
                    PH_CHECKSUM:  checksum_next  = shift_in[31:0];
                    PH_PRIORITY:  priority_next  = shift_in[7:0];
                    PH_CODEC:     codec_next     = shift_in[7:0];
                    PH_KEYLEN:
                    begin
                        key_len_next = shift_in[31:0];
                        phase_next   = (shift_in[31:0] != 32'd0) ? PH_KEY : PH_VALLEN;
                    end
                    default:
                    begin
                        value_len_next = shift_in[31:0];
                        phase_next     = (shift_in[31:0] != 32'd0) ? PH_VALUE : PH_DONE;
                    end
                endcase
            end
            else
            begin
                count_next = count_inc;
                shift_next = shift_in;
            end
        end
        else if (accept && is_body)
        begin
            crc_next = crc32_byte(crc_reg, rx.in_byte);
            if (count_inc == body_len)
            begin
                phase_next = (phase_reg == PH_KEY) ? PH_VALLEN : PH_DONE;
                count_next = 32'd0;
                shift_next = 64'd0;
            end
            else
            begin
                count_next = count_inc;
            end
        end

        sum.offset     = offset_next;
        sum.timestamp  = timestamp_next;
        sum.partition  = partition_next;
        sum.checksum   = checksum_next;
        sum.priority_b = priority_next;
        sum.codec      = codec_next;
        sum.key_len    = key_len_next;
        sum.value_len  = value_len_next;
        sum.valid      = (phase_next == PH_DONE);
        sum.crc_match  = (phase_next == PH_DONE) && ((crc_next ^ CRC_ONES) == checksum_next);

        // restart for the next message after the marked last byte
        if (accept && rx.end_of_buffer)
        begin
            phase_next     = PH_OFFSET;
            count_next     = 32'd0;
            shift_next     = 64'd0;
            crc_next       = CRC_ONES;
            offset_next    = 64'd0;
            timestamp_next = 64'd0;
            partition_next = 32'd0;
            checksum_next  = 32'd0;
            priority_next  = 8'd0;
            codec_next     = 8'd0;
            key_len_next   = 32'd0;
            value_len_next = 32'd0;
        end
    end

    always_comb
    begin
        push.valid           = accept && (is_body || rx.end_of_buffer);
        push.entry.has_data  = is_body;
        push.entry.is_value  = (phase_reg == PH_VALUE);
        push.entry.data_byte = rx.in_byte;
        push.entry.has_sum   = rx.end_of_buffer;
        push.entry.sum       = sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_OFFSET;
            count_reg     <= 32'd0;
            shift_reg     <= 64'd0;
            crc_reg       <= CRC_ONES;
            offset_reg    <= 64'd0;
            timestamp_reg <= 64'd0;
            partition_reg <= 32'd0;
            checksum_reg  <= 32'd0;
            priority_reg  <= 8'd0;
            codec_reg     <= 8'd0;
            key_len_reg   <= 32'd0;
            value_len_reg <= 32'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            shift_reg     <= shift_next;
            crc_reg       <= crc_next;
            offset_reg    <= offset_next;
            timestamp_reg <= timestamp_next;
            partition_reg <= partition_next;
            checksum_reg  <= checksum_next;
            priority_reg  <= priority_next;
            codec_reg     <= codec_next;
            key_len_reg   <= key_len_next;
            value_len_reg <= value_len_next;
        end
    end

endmodule

[sv/dfc_queue.sv]
// Short entry queue between the front parser and the back beat sequencer.
module dfc_queue
    import dfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  qlink_t push,
    output logic   full,
    output qlink_t pop,
    input  logic   pop_ready
);

    entry_t mem [QUEUE_DEPTH];

    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   fill_reg,   fill_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (fill_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign do_push   = push.valid && !full;
    assign do_pop    = pop.valid && pop_ready;
    assign pop.valid = (fill_reg != '0);
    assign pop.entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        fill_next   = fill_reg + (QUEUE_AW+1)'(do_push) - (QUEUE_AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[sv/dfc_back.sv]
// Back sequencer: holds one queued entry and sends its data and summary beats.
module dfc_back
    import dfc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  qlink_t pop,
    output logic   pop_ready,
    dfc_out_if.source tx
);

    entry_t cur_reg;
    logic   cur_valid_reg, cur_valid_next;
    logic   sent_reg,      sent_next;
    logic   emit_data;
    logic   beat_done;
    logic   finish;

    assign emit_data = cur_reg.has_data && !sent_reg;
    assign beat_done = tx.valid && tx.ready;
    assign finish    = beat_done && !(emit_data && cur_reg.has_sum);
    assign pop_ready = !cur_valid_reg || finish;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        sent_next      = sent_reg;
        if (pop_ready)
        begin
            cur_valid_next = pop.valid;
            sent_next      = 1'b0;
        end
        else if (beat_done)
        begin
            sent_next = 1'b1;
        end
    end

    always_comb
    begin
        tx.valid = cur_valid_reg;
        if (emit_data)
        begin
            tx.kind          = cur_reg.is_value ? KIND_VALUE : KIND_KEY;
            tx.payload_byte  = cur_reg.data_byte;
            tx.msg_offset    = 64'd0;
            tx.msg_timestamp = 64'd0;
            tx.msg_partition = 32'd0;
            tx.stored_crc    = 32'd0;
            tx.msg_priority  = 8'd0;
            tx.msg_codec     = 8'd0;
            tx.key_length    = 32'd0;
            tx.value_length  = 32'd0;
            tx.msg_valid     = 1'b0;
            tx.crc_match     = 1'b0;
        end
        else
        begin
            tx.kind          = KIND_SUMMARY;
            tx.payload_byte  = 8'd0;
            tx.msg_offset    = cur_reg.sum.offset;
            tx.msg_timestamp = cur_reg.sum.timestamp;
            tx.msg_partition = cur_reg.sum.partition;
            tx.stored_crc    = cur_reg.sum.checksum;
            tx.msg_priority  = cur_reg.sum.priority_b;
            tx.msg_codec     = cur_reg.sum.codec;
            tx.key_length    = cur_reg.sum.key_len;
            tx.value_length  = cur_reg.sum.value_len;
            tx.msg_valid     = cur_reg.sum.valid;
            tx.crc_match     = cur_reg.sum.crc_match;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_ready && pop.valid)
        begin
            cur_reg <= pop.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sent_reg      <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            sent_reg      <= sent_next;
        end
    end

endmodule

[sv/dfc_checker.sv]
// Port-level assertions for the deframer top level, with the bind that attaches them.
module dfc_checker
    import dfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       tx_valid,
    input logic       tx_ready,
    input logic [1:0] tx_kind,
    input logic [7:0] tx_payload_byte,
    input logic       tx_msg_valid,
    input logic       tx_crc_match
);

    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid |-> (tx_kind == KIND_KEY || tx_kind == KIND_VALUE || tx_kind == KIND_SUMMARY))
        else $error("tx kind out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_kind != KIND_SUMMARY |-> !tx_msg_valid && !tx_crc_match)
        else $error("flags set on a data beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && tx_crc_match |-> tx_msg_valid)
        else $error("crc match on a truncated message");

    assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_kind) && $stable(tx_payload_byte))
        else $error("stalled tx beat changed");

endmodule

bind message_deframer_crc32_check_top dfc_checker u_dfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .tx_valid        (tx.valid),
    .tx_ready        (tx.ready),
    .tx_kind         (tx.kind),
    .tx_payload_byte (tx.payload_byte),
    .tx_msg_valid    (tx.msg_valid),
    .tx_crc_match    (tx.crc_match)
);
